// ===== rtl/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, constants and arithmetic helpers for the great circle
// distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  typedef logic signed [35:0] ang_t;
  typedef logic signed [33:0] cval_t;
  typedef logic signed [36:0] prod_t;

  localparam ang_t HALF_PI     = 36'sd1686629713;
  localparam ang_t NEG_HALF_PI = -36'sd1686629713;
  localparam ang_t PI          = 36'sd3373259426;
  localparam ang_t NEG_PI      = -36'sd3373259426;
  localparam ang_t TWO_PI      = 36'sd6746518852;
  localparam cval_t INV_GAIN   = 34'sh026DD3B6A;
  localparam logic [30:0] Q30_ONE = 31'h40000000;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_FACTOR = 1'b1;

  localparam logic [12:0] RADIUS_RST = 13'd6371;
  localparam logic [15:0] FACTOR_RST = 16'd40722;

  function automatic logic [31:0] atan_at(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      24: r = 32'h0000003F;
      25: r = 32'h0000001F;
      26: r = 32'h0000000F;
      27: r = 32'h00000008;
      28: r = 32'h00000004;
      29: r = 32'h00000002;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // sign-magnitude Q30 product, truncated toward zero
  function automatic prod_t mul_q30(input cval_t a, input cval_t b);
    logic [32:0] ma;
    logic [32:0] mb;
    logic [65:0] pr;
    prod_t p;
    ma = a[33] ? 33'(-a) : a[32:0];
    mb = b[33] ? 33'(-b) : b[32:0];
    pr = ma * mb;
    p  = prod_t'({1'b0, pr[65:30]});
    return (a[33] != b[33]) ? -p : p;
  endfunction

endpackage

// ===== rtl/great_circle_distance_top.sv =====
// ----------------------------------------------------------------------------
// great_circle_distance_top
// Haversine great circle distance between two positions, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one position pair per cycle unless stalled and returns one distance
// word per pair, in order. The depth is set by the sine/cosine CORDIC
// (CORDIC_STEPS + 1 stages), three product stages, the square-root pipeline
// (32 stages), the atan2 CORDIC (CORDIC_STEPS + 1 stages), two scaling
// stages and the output register. A stall on the result side freezes the
// whole pipeline; nothing is lost or repeated.
module great_circle_distance_top #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [30:0] in_start_lat,
  input  logic signed [31:0] in_start_lon,
  input  logic signed [30:0] in_end_lat,
  input  logic signed [31:0] in_end_lon,
  input  logic               in_to_miles,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [22:0]        out_distance,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata
);

  logic               en;
  logic [12:0]        radius_r;
  logic [15:0]        factor_r;
  gcd_pkg::ang_t      dlat, dlon, lat1x2, lat2x2;
  logic               r_v, r_mi;
  gcd_pkg::cval_t     s_lat, s_lon, c1, c2;
  logic               m1_v_r, m1_mi_r;
  gcd_pkg::prod_t     p1_r;
  gcd_pkg::cval_t     p2_r, p3_r;
  logic               m2_v_r, m2_mi_r;
  gcd_pkg::prod_t     p1d_r, p4_r;
  logic               a_v_r, a_mi_r;
  logic [30:0]        a_r;
  logic signed [37:0] a_sum;
  logic [30:0]        a_nxt;
  logic               sq_v, sq_mi;
  logic [30:0]        ra, rb;
  logic               z_v, z_mi;
  logic [30:0]        z;
  logic               d1_v_r, d1_mi_r;
  logic [44:0]        d1_r;
  logic               d2_v_r;
  logic [44:0]        d2_r;
  logic [60:0]        d_mul;
  logic               out_valid_r;
  logic [22:0]        out_distance_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= gcd_pkg::RADIUS_RST;
      factor_r <= gcd_pkg::FACTOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gcd_pkg::CFG_RADIUS: radius_r <= cfg_wdata[12:0];
        gcd_pkg::CFG_FACTOR: factor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // half differences read directly as Q30, latitudes doubled for cosine
  assign dlat   = gcd_pkg::ang_t'(in_end_lat) - gcd_pkg::ang_t'(in_start_lat);
  assign dlon   = gcd_pkg::ang_t'(in_end_lon) - gcd_pkg::ang_t'(in_start_lon);
  assign lat1x2 = gcd_pkg::ang_t'(in_start_lat) <<< 1;
  assign lat2x2 = gcd_pkg::ang_t'(in_end_lat) <<< 1;

  gcd_rot_cordic #(.STEPS(CORDIC_STEPS), .TAG_W(1)) u_rot_dlat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid), .in_angle(dlat),
    .in_tag(in_to_miles), .out_valid(r_v), .out_sin(s_lat), .out_cos(),
    .out_tag(r_mi)
  );
  gcd_rot_cordic #(.STEPS(CORDIC_STEPS), .TAG_W(1)) u_rot_dlon (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid), .in_angle(dlon),
    .in_tag(1'b0), .out_valid(), .out_sin(s_lon), .out_cos(), .out_tag()
  );
  gcd_rot_cordic #(.STEPS(CORDIC_STEPS), .TAG_W(1)) u_rot_lat1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid), .in_angle(lat1x2),
    .in_tag(1'b0), .out_valid(), .out_sin(), .out_cos(c1), .out_tag()
  );
  gcd_rot_cordic #(.STEPS(CORDIC_STEPS), .TAG_W(1)) u_rot_lat2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid), .in_angle(lat2x2),
    .in_tag(1'b0), .out_valid(), .out_sin(), .out_cos(c2), .out_tag()
  );

  // haversine term
  assign a_sum = 38'(p1d_r) + 38'(p4_r);
  always_comb begin
    if (a_sum[37]) begin
      a_nxt = '0;
    end else if (a_sum > 38'(gcd_pkg::Q30_ONE)) begin
      a_nxt = gcd_pkg::Q30_ONE;
    end else begin
      a_nxt = a_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      a_v_r  <= 1'b0;
    end else if (en) begin
      m1_v_r <= r_v;
      m2_v_r <= m1_v_r;
      a_v_r  <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_mi_r <= r_mi;
      p1_r    <= gcd_pkg::mul_q30(s_lat, s_lat);
      p2_r    <= gcd_pkg::cval_t'(gcd_pkg::mul_q30(s_lon, s_lon));
      p3_r    <= gcd_pkg::cval_t'(gcd_pkg::mul_q30(c1, c2));
      m2_mi_r <= m1_mi_r;
      p1d_r   <= p1_r;
      p4_r    <= gcd_pkg::mul_q30(p2_r, p3_r);
      a_mi_r  <= m2_mi_r;
      a_r     <= a_nxt;
    end
  end

  gcd_sqrt #(.TAG_W(1)) u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(a_v_r), .in_a(a_r),
    .in_tag(a_mi_r), .out_valid(sq_v), .out_root(ra), .out_tag(sq_mi)
  );
  gcd_sqrt #(.TAG_W(1)) u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(a_v_r),
    .in_a(gcd_pkg::Q30_ONE - a_r), .in_tag(1'b0), .out_valid(),
    .out_root(rb), .out_tag()
  );

  gcd_vec_cordic #(.STEPS(CORDIC_STEPS), .TAG_W(1)) u_vec (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_v), .in_y(ra), .in_x(rb),
    .in_tag(sq_mi), .out_valid(z_v), .out_z(z), .out_tag(z_mi)
  );

  // scaling
  assign d_mul = d1_r * factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r      <= 1'b0;
      d2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      d1_v_r      <= z_v;
      d2_v_r      <= d1_v_r;
      out_valid_r <= d2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_mi_r        <= z_mi;
      d1_r           <= {z, 1'b0} * radius_r;
      d2_r           <= d1_mi_r ? d_mul[60:16] : d1_r;
      out_distance_r <= d2_r[44:22];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r |-> a_r <= gcd_pkg::Q30_ONE)
    else $error("haversine term above one");

  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(m1_v_r) && $stable(m2_v_r) && $stable(a_v_r) && $stable(d1_v_r))
    else $error("pipeline moved while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && d2_v_r) |=> $stable(d2_r))
    else $error("scaled word changed while stalled");

endmodule

// ===== rtl/gcd_rot_cordic.sv =====
// ----------------------------------------------------------------------------
// gcd_rot_cordic
// Pipelined rotation CORDIC: angle reduction stage, then one stage per
// iteration. Gives sine and cosine in Q30.
// ----------------------------------------------------------------------------
module gcd_rot_cordic #(
  parameter int STEPS = 24,
  parameter int TAG_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  gcd_pkg::ang_t       in_angle,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output gcd_pkg::cval_t      out_sin,
  output gcd_pkg::cval_t      out_cos,
  output logic [TAG_W-1:0]    out_tag
);

  gcd_pkg::cval_t   x_r [0:STEPS];
  gcd_pkg::cval_t   y_r [0:STEPS];
  gcd_pkg::ang_t    th_r [0:STEPS];
  logic             flip_r [0:STEPS];
  logic [TAG_W-1:0] tag_r [0:STEPS];
  gcd_pkg::cval_t   x_nxt [0:STEPS];
  gcd_pkg::cval_t   y_nxt [0:STEPS];
  gcd_pkg::ang_t    th_nxt [0:STEPS];
  logic             flip_nxt [0:STEPS];
  logic [TAG_W-1:0] tag_nxt [0:STEPS];
  logic [STEPS:0]   v_r;

  always_comb begin
    gcd_pkg::ang_t t0;
    t0 = in_angle;
    if (t0 > gcd_pkg::PI) begin
      t0 = t0 - gcd_pkg::TWO_PI;
    end else if (t0 < gcd_pkg::NEG_PI) begin
      t0 = t0 + gcd_pkg::TWO_PI;
    end
    flip_nxt[0] = 1'b0;
    th_nxt[0]   = t0;
    if (t0 > gcd_pkg::HALF_PI) begin
      th_nxt[0]   = t0 - gcd_pkg::PI;
      flip_nxt[0] = 1'b1;
    end else if (t0 < gcd_pkg::NEG_HALF_PI) begin
      th_nxt[0]   = t0 + gcd_pkg::PI;
      flip_nxt[0] = 1'b1;
    end
    x_nxt[0]   = gcd_pkg::INV_GAIN;
    y_nxt[0]   = '0;
    tag_nxt[0] = in_tag;
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    gcd_pkg::ang_t at;
    assign at = gcd_pkg::ang_t'(gcd_pkg::atan_at(g));
    assign x_nxt[g+1]    = th_r[g][35] ? x_r[g] + (y_r[g] >>> g) : x_r[g] - (y_r[g] >>> g);
    assign y_nxt[g+1]    = th_r[g][35] ? y_r[g] - (x_r[g] >>> g) : y_r[g] + (x_r[g] >>> g);
    assign th_nxt[g+1]   = th_r[g][35] ? th_r[g] + at : th_r[g] - at;
    assign flip_nxt[g+1] = flip_r[g];
    assign tag_nxt[g+1]  = tag_r[g];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= STEPS; k++) begin
        x_r[k]    <= x_nxt[k];
        y_r[k]    <= y_nxt[k];
        th_r[k]   <= th_nxt[k];
        flip_r[k] <= flip_nxt[k];
        tag_r[k]  <= tag_nxt[k];
      end
    end
  end

  assign out_valid = v_r[STEPS];
  assign out_sin   = flip_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
  assign out_cos   = flip_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
  assign out_tag   = tag_r[STEPS];

endmodule

// ===== rtl/gcd_sqrt.sv =====
// ----------------------------------------------------------------------------
// gcd_sqrt
// Pipelined integer square root of (a << 30), one result bit per stage.
// ----------------------------------------------------------------------------
module gcd_sqrt #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [30:0]      in_a,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [30:0]      out_root,
  output logic [TAG_W-1:0] out_tag
);

  localparam int NS = 31;

  logic [32:0]      rem_r [0:NS];
  logic [30:0]      root_r [0:NS];
  logic [30:0]      a_r [0:NS];
  logic [TAG_W-1:0] tag_r [0:NS];
  logic [32:0]      rem_nxt [0:NS];
  logic [30:0]      root_nxt [0:NS];
  logic [30:0]      a_nxt [0:NS];
  logic [TAG_W-1:0] tag_nxt [0:NS];
  logic [NS:0]      v_r;

  assign rem_nxt[0]  = '0;
  assign root_nxt[0] = '0;
  assign a_nxt[0]    = in_a;
  assign tag_nxt[0]  = in_tag;

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int P = NS - 1 - k;
    logic [61:0] vv;
    logic [34:0] rt;
    logic [34:0] tst;
    logic        ge;
    assign vv  = {1'b0, a_r[k], 30'b0};
    assign rt  = {rem_r[k], vv[2*P+1 -: 2]};
    assign tst = {2'b00, root_r[k], 2'b01};
    assign ge  = rt >= tst;
    assign rem_nxt[k+1]  = ge ? 33'(rt - tst) : rt[32:0];
    assign root_nxt[k+1] = {root_r[k][29:0], ge};
    assign a_nxt[k+1]    = a_r[k];
    assign tag_nxt[k+1]  = tag_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= NS; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        a_r[k]    <= a_nxt[k];
        tag_r[k]  <= tag_nxt[k];
      end
    end
  end

  assign out_valid = v_r[NS];
  assign out_root  = root_r[NS];
  assign out_tag   = tag_r[NS];

endmodule

// ===== rtl/gcd_vec_cordic.sv =====
// ----------------------------------------------------------------------------
// gcd_vec_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in Q30 for non-negative inputs,
// negative angles clamped to zero.
// ----------------------------------------------------------------------------
module gcd_vec_cordic #(
  parameter int STEPS = 24,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [30:0]      in_y,
  input  logic [30:0]      in_x,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [30:0]      out_z,
  output logic [TAG_W-1:0] out_tag
);

  gcd_pkg::cval_t   x_r [0:STEPS];
  gcd_pkg::cval_t   y_r [0:STEPS];
  gcd_pkg::cval_t   z_r [0:STEPS];
  logic             zero_r [0:STEPS];
  logic [TAG_W-1:0] tag_r [0:STEPS];
  gcd_pkg::cval_t   x_nxt [0:STEPS];
  gcd_pkg::cval_t   y_nxt [0:STEPS];
  gcd_pkg::cval_t   z_nxt [0:STEPS];
  logic             zero_nxt [0:STEPS];
  logic [TAG_W-1:0] tag_nxt [0:STEPS];
  logic [STEPS:0]   v_r;

  assign x_nxt[0]    = gcd_pkg::cval_t'({3'b000, in_x});
  assign y_nxt[0]    = gcd_pkg::cval_t'({3'b000, in_y});
  assign z_nxt[0]    = '0;
  assign zero_nxt[0] = (in_y == '0);
  assign tag_nxt[0]  = in_tag;

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    gcd_pkg::cval_t at;
    logic           pos;
    assign at  = gcd_pkg::cval_t'(gcd_pkg::atan_at(g));
    assign pos = !y_r[g][33] && (y_r[g] != '0);
    assign x_nxt[g+1]    = pos ? x_r[g] + (y_r[g] >>> g) : x_r[g] - (y_r[g] >>> g);
    assign y_nxt[g+1]    = pos ? y_r[g] - (x_r[g] >>> g) : y_r[g] + (x_r[g] >>> g);
    assign z_nxt[g+1]    = pos ? z_r[g] + at : z_r[g] - at;
    assign zero_nxt[g+1] = zero_r[g];
    assign tag_nxt[g+1]  = tag_r[g];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= STEPS; k++) begin
        x_r[k]    <= x_nxt[k];
        y_r[k]    <= y_nxt[k];
        z_r[k]    <= z_nxt[k];
        zero_r[k] <= zero_nxt[k];
        tag_r[k]  <= tag_nxt[k];
      end
    end
  end

  assign out_valid = v_r[STEPS];
  assign out_z     = (zero_r[STEPS] || z_r[STEPS][33]) ? '0 : z_r[STEPS][30:0];
  assign out_tag   = tag_r[STEPS];

endmodule

// ===== dv/great_circle_distance_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_checker
// Watches the position and distance channels of the great circle distance
// block, predicts each distance from the accepted position pair and the
// current register values, and compares results in order.
// ----------------------------------------------------------------------------
module great_circle_distance_checker #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [30:0] in_start_lat,
  input  logic signed [31:0] in_start_lon,
  input  logic signed [30:0] in_end_lat,
  input  logic signed [31:0] in_end_lon,
  input  logic               in_to_miles,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [22:0]        out_distance,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint HPI_Q30  = 64'sd1686629713;
  localparam longint PI_Q30L  = 64'sd3373259426;
  localparam longint TPI_Q30  = 64'sd6746518852;
  localparam longint GAIN_Q30 = 64'sh26DD3B6A;
  localparam longint unsigned DIST_SAT = 64'd8388607;

  localparam longint ATAN_TBL [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  logic [12:0]  radius_km;
  logic [15:0]  mile_factor;
  logic [22:0]  distance_q[$];
  int           mismatches;

  assign pending    = distance_q.size();
  assign fail_count = mismatches;

  function automatic longint qmul(input longint a, input longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint p;
    ma = (a < 0) ? longint'(-a) : a;
    mb = (b < 0) ? longint'(-b) : b;
    p  = longint'((ma * mb) >> 30);
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic void rotate_sincos(input longint theta, output longint s,
                                        output longint c);
    longint th;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    th = theta;
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    while (th > PI_Q30L) th -= TPI_Q30;
    while (th < -PI_Q30L) th += TPI_Q30;
    if (th > HPI_Q30) begin
      th -= PI_Q30L;
      flip = 1;
    end else if (th < -HPI_Q30) begin
      th += PI_Q30L;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (th >= 0) begin
        x -= dx; y += dy; th -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; th += ATAN_TBL[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint vector_angle(input longint yin, input longint xin);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = xin;
    y = yin;
    z = 0;
    if (y == 0) return 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [22:0] predict_distance(
      input longint slat, input longint slon, input longint elat,
      input longint elon, input bit miles, input logic [12:0] rad,
      input logic [15:0] fac);
    longint sl;
    longint sn;
    longint c1;
    longint c2;
    longint tmp;
    longint a;
    longint z;
    longint unsigned ra;
    longint unsigned rb;
    longint unsigned d;
    rotate_sincos(elat - slat, sl, tmp);
    rotate_sincos(elon - slon, sn, tmp);
    rotate_sincos(slat * 2, tmp, c1);
    rotate_sincos(elat * 2, tmp, c2);
    a = qmul(sl, sl) + qmul(qmul(sn, sn), qmul(c1, c2));
    if (a < 0) a = 0;
    if (a > ONE_Q30) a = ONE_Q30;
    ra = int_sqrt(longint'(a) << 30);
    rb = int_sqrt(longint'(ONE_Q30 - a) << 30);
    z = vector_angle(ra, rb);
    if (z < 0) z = 0;
    d = longint'(z * 2) * longint'(rad);
    if (miles) d = (d * longint'(fac)) >> 16;
    d >>= 22;
    if (d > DIST_SAT) d = DIST_SAT;
    return d[22:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      radius_km   <= gcd_pkg::RADIUS_RST;
      mile_factor <= gcd_pkg::FACTOR_RST;
      mismatches  <= 0;
      distance_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == gcd_pkg::CFG_RADIUS) radius_km <= cfg_wdata[12:0];
        else mile_factor <= cfg_wdata;
      end
      if (in_valid && !in_stall)
        distance_q.push_back(predict_distance(in_start_lat, in_start_lon,
                                              in_end_lat, in_end_lon,
                                              in_to_miles, radius_km,
                                              mile_factor));
      if (out_valid && !out_stall) begin
        if (distance_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected distance word %0d at %0t", out_distance, $realtime);
          mismatches <= mismatches + 1;
        end else begin
          if (out_distance !== distance_q[0]) begin
            if (mismatches < 10)
              $display("distance mismatch: expected %0d actual %0d at %0t",
                       distance_q[0], out_distance, $realtime);
            mismatches <= mismatches + 1;
          end
          void'(distance_q.pop_front());
        end
      end
    end
  end

endmodule

// ===== dv/great_circle_distance_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_top_test
// Drives directed and random position pairs through the distance block over
// several register settings, with bursty input, random and long output
// stalls; the checker predicts and compares every distance word.
// ----------------------------------------------------------------------------
module great_circle_distance_top_test;

  localparam int LAT_MAX = 843314857;
  localparam int LON_MAX = 1686629713;
  localparam int DRAIN   = 2 * 24 + 40 + 20;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [30:0] in_start_lat = 0;
  logic signed [31:0] in_start_lon = 0;
  logic signed [30:0] in_end_lat = 0;
  logic signed [31:0] in_end_lon = 0;
  logic               in_to_miles = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [22:0]        out_distance;
  logic               cfg_we = 0;
  logic               cfg_index = gcd_pkg::CFG_RADIUS;
  logic [15:0]        cfg_wdata = 0;
  int                 fail_count;
  int                 pending;
  int                 burst_left = 0;

  great_circle_distance_top #(.CORDIC_STEPS(24)) dut (.*);
  great_circle_distance_checker #(.CORDIC_STEPS(24)) u_checker (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: rotating stall modes plus one long hold-off
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 256 == 0) mode = $urandom_range(0, 3);
      if (cyc >= 3000 && cyc < 3400) out_stall <= 1;
      else case (mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  task automatic send_word(input logic [30:0] slat, input logic [31:0] slon,
                           input logic [30:0] elat, input logic [31:0] elon,
                           input logic miles);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid     <= 1;
    in_start_lat <= slat;
    in_start_lon <= slon;
    in_end_lat   <= elat;
    in_end_lon   <= elon;
    in_to_miles  <= miles;
    do @(posedge clk); while (in_stall);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic idle_write(input logic idx, input logic [15:0] val);
    in_valid <= 0;
    burst_left = 0;
    wait (pending == 0);
    repeat (DRAIN) @(negedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_lon();
    return $urandom_range(0, 3) == 0 ? $urandom()
                                     : 32'($signed($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
  endfunction

  function automatic logic [30:0] rand_lat();
    return $urandom_range(0, 3) == 0 ? 31'($urandom())
                                     : 31'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
  endfunction

  initial begin
    logic [15:0] rads [6];
    logic [15:0] facs [6];
    logic [30:0] la;
    logic [31:0] lo;
    rads = '{16'd6371, 16'd1, 16'd8191, 16'd8191, 16'd1, 16'd0};
    facs = '{16'd40722, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: extremes, same point, antipodes, out-of-range patterns
    send_word(0, 0, 0, 0, 0);
    send_word(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, 1);
    send_word(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 0);
    send_word(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 1);
    send_word(0, 0, 0, LON_MAX, 0);
    send_word(0, -LON_MAX, 0, LON_MAX, 0);
    send_word(0, -LON_MAX, 0, LON_MAX, 1);
    send_word(LAT_MAX, 0, -LAT_MAX, 0, 0);
    send_word(31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000, 0);
    send_word(31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF, 1);
    send_word(31'h7FFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF, 1);
    send_word(31'h55555555, 32'hAAAAAAAA, 31'h2AAAAAAA, 32'h55555555, 0);
    send_word(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, 1);
    send_word(1, 1, 0, 0, 0);
    send_word(100, -100, 101, -99, 1);
    for (int ph = 0; ph < 6; ph++) begin
      idle_write(gcd_pkg::CFG_RADIUS, rads[ph]);
      idle_write(gcd_pkg::CFG_FACTOR, facs[ph]);
      if (ph == 5) begin
        idle_write(gcd_pkg::CFG_RADIUS, 16'($urandom_range(1, 8191)));
        idle_write(gcd_pkg::CFG_FACTOR, 16'($urandom()));
      end
      for (int k = 0; k < 325; k++) begin
        la = rand_lat();
        lo = rand_lon();
        if ($urandom_range(0, 9) == 0)
          send_word(la, lo, la + 31'($urandom_range(0, 64)) - 32,
                    lo + $urandom_range(0, 64) - 32, $urandom_range(0, 1));
        else
          send_word(la, lo, rand_lat(), rand_lon(), $urandom_range(0, 1));
      end
    end
    in_valid <= 0;
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
